### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is asserted.
`define TBIM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tbim assertion failed");

// Clocked check that also runs through reset.
`define TBIM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tbim reset assertion failed");

`endif

### hw/rtl/tbim_pkg.sv
// Shared types for the two-body invariant mass unit.
package tbim_pkg;

  // Sideband that travels with every pipeline stage.
  typedef struct packed {
    logic valid;
    logic no_real_root;
  } tbim_tag_t;

endpackage

### hw/rtl/tbim_prep.sv
// Front pipeline: four-vector sum, squares, momentum sum and squared mass.
module tbim_prep #(
  parameter int W = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  logic                    in_valid,
  input  logic signed [W-1:0]     energy_a,
  input  logic signed [W-1:0]     mom_x_a,
  input  logic signed [W-1:0]     mom_y_a,
  input  logic signed [W-1:0]     mom_z_a,
  input  logic signed [W-1:0]     energy_b,
  input  logic signed [W-1:0]     mom_x_b,
  input  logic signed [W-1:0]     mom_y_b,
  input  logic signed [W-1:0]     mom_z_b,
  output tbim_pkg::tbim_tag_t     tag_out,
  output logic [2*W+1:0]          radicand
);
  import tbim_pkg::*;

  localparam int SW  = W + 1;     // component sum
  localparam int SQW = 2 * W + 1; // one square, also squared mass
  localparam int PW  = 2 * W + 2; // signed product, sum of three squares
  localparam int DW  = 2 * W + 3; // difference with sign

  logic [3:0] v_r;

  logic signed [SW-1:0] sum_e_r, sum_x_r, sum_y_r, sum_z_r;
  logic signed [PW-1:0] prod_e, prod_x, prod_y, prod_z;
  logic [SQW-1:0]       sq_e_r, sq_x_r, sq_y_r, sq_z_r;
  logic [SQW-1:0]       sq_e3_r;
  logic [PW-1:0]        p2_r;
  logic [DW-1:0]        diff;
  logic [SQW-1:0]       m2_r;
  logic                 nrr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (advance) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_comb begin
    prod_e = PW'(sum_e_r) * PW'(sum_e_r);
    prod_x = PW'(sum_x_r) * PW'(sum_x_r);
    prod_y = PW'(sum_y_r) * PW'(sum_y_r);
    prod_z = PW'(sum_z_r) * PW'(sum_z_r);
    diff   = DW'(sq_e3_r) - DW'(p2_r);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // stage 1: component sums
      sum_e_r <= SW'(energy_a) + SW'(energy_b);
      sum_x_r <= SW'(mom_x_a) + SW'(mom_x_b);
      sum_y_r <= SW'(mom_y_a) + SW'(mom_y_b);
      sum_z_r <= SW'(mom_z_a) + SW'(mom_z_b);
      // stage 2: squares are never negative, drop the sign bit
      sq_e_r  <= prod_e[SQW-1:0];
      sq_x_r  <= prod_x[SQW-1:0];
      sq_y_r  <= prod_y[SQW-1:0];
      sq_z_r  <= prod_z[SQW-1:0];
      // stage 3: momentum magnitude squared
      sq_e3_r <= sq_e_r;
      p2_r    <= PW'(sq_x_r) + PW'(sq_y_r) + PW'(sq_z_r);
      // stage 4: squared mass, clamped to zero when negative
      nrr_r   <= diff[DW-1];
      m2_r    <= diff[DW-1] ? '0 : diff[SQW-1:0];
    end
  end

  assign tag_out  = '{valid: v_r[3], no_real_root: nrr_r};
  assign radicand = PW'(m2_r);

endmodule

### hw/rtl/tbim_sqrt.sv
// Pipelined floor square root, one result bit per stage.
module tbim_sqrt #(
  parameter int W = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  tbim_pkg::tbim_tag_t     tag_in,
  input  logic [2*W+1:0]          radicand,
  output tbim_pkg::tbim_tag_t     tag_out,
  output logic [W:0]              root
);
  import tbim_pkg::*;

  localparam int R    = W + 1;     // root bits, one per stage
  localparam int RADW = 2 * R;     // radicand bits, two consumed per stage
  localparam int RW   = R + 2;     // partial remainder

  logic [RADW-1:0] rad_r  [R];
  logic [RW-1:0]   rem_r  [R];
  logic [R-1:0]    root_r [R];
  tbim_tag_t       tag_r  [R];

  for (genvar k = 0; k < R; k++) begin : g_stage
    logic [RADW-1:0] rad_i;
    logic [RW-1:0]   rem_i;
    logic [R-1:0]    root_i;
    tbim_tag_t       tag_i;
    logic [RW-1:0]   cur;
    logic [RW-1:0]   trial;
    logic            ge;

    if (k == 0) begin : g_head
      assign rad_i  = radicand;
      assign rem_i  = '0;
      assign root_i = '0;
      assign tag_i  = tag_in;
    end else begin : g_body
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign tag_i  = tag_r[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign cur   = {rem_i[RW-3:0], rad_i[RADW-1 -: 2]};
    assign trial = {root_i, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (advance) begin
        rad_r[k]  <= {rad_i[RADW-3:0], 2'b00};
        rem_r[k]  <= ge ? (cur - trial) : cur;
        root_r[k] <= {root_i[R-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k] <= '0;
      end else if (advance) begin
        tag_r[k] <= tag_i;
      end
    end
  end

  assign tag_out = tag_r[R-1];
  assign root    = root_r[R-1];

endmodule

### hw/rtl/tbim_skid.sv
// Output register with a skid entry so the pipeline stall is registered.
module tbim_skid #(
  parameter int MW = 21
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tbim_pkg::tbim_tag_t     tag_in,
  input  logic [MW-1:0]           mass_in,
  output logic                    advance,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [MW-1:0]           out_mass,
  output logic                    out_no_real_root
);
  import tbim_pkg::*;

  logic          main_v_r, skid_v_r;
  logic          main_v_nxt, skid_v_nxt;
  logic [MW-1:0] main_mass_r, skid_mass_r;
  logic          main_nrr_r, skid_nrr_r;
  logic          push;
  logic          main_free;

  assign advance   = !skid_v_r;
  assign push      = tag_in.valid && advance;
  assign main_free = !main_v_r || !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (main_free) begin
      // skid entry drains first; no push can happen while it is full
      main_v_nxt = skid_v_r || push;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_v_r) begin
        main_mass_r <= skid_mass_r;
        main_nrr_r  <= skid_nrr_r;
      end else if (push) begin
        main_mass_r <= mass_in;
        main_nrr_r  <= tag_in.no_real_root;
      end
    end else if (push) begin
      skid_mass_r <= mass_in;
      skid_nrr_r  <= tag_in.no_real_root;
    end
  end

  assign out_valid        = main_v_r;
  assign out_mass         = main_mass_r;
  assign out_no_real_root = main_nrr_r;

endmodule

### hw/rtl/two_body_invariant_mass_unit.sv
// Invariant mass of two four-vectors: the components are summed pairwise, the
// squared mass E^2 - |p|^2 is formed exactly, and the floor square root is
// returned; a negative squared mass gives mass 0 with out_no_real_root set.
// One transaction is accepted per clock while in_stall is low. Results pass
// through registered sum, square, momentum sum and subtraction stages, the
// square root pipeline with a stage per root bit (COMPONENT_WIDTH + 1
// stages) and the output register. in_stall comes from a flop and rises only
// after the output has been held off.
module two_body_invariant_mass_unit #(
  parameter int COMPONENT_WIDTH = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0] in_energy_a,
  input  logic signed [COMPONENT_WIDTH-1:0] in_mom_x_a,
  input  logic signed [COMPONENT_WIDTH-1:0] in_mom_y_a,
  input  logic signed [COMPONENT_WIDTH-1:0] in_mom_z_a,
  input  logic signed [COMPONENT_WIDTH-1:0] in_energy_b,
  input  logic signed [COMPONENT_WIDTH-1:0] in_mom_x_b,
  input  logic signed [COMPONENT_WIDTH-1:0] in_mom_y_b,
  input  logic signed [COMPONENT_WIDTH-1:0] in_mom_z_b,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [COMPONENT_WIDTH:0]         out_mass,
  output logic                             out_no_real_root
);
  import tbim_pkg::*;

  localparam int W = COMPONENT_WIDTH;

  logic            advance;
  tbim_tag_t       prep_tag;
  logic [2*W+1:0]  radicand;
  tbim_tag_t       root_tag;
  logic [W:0]      root;

  tbim_prep #(.W(W)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_valid (in_valid),
    .energy_a (in_energy_a),
    .mom_x_a  (in_mom_x_a),
    .mom_y_a  (in_mom_y_a),
    .mom_z_a  (in_mom_z_a),
    .energy_b (in_energy_b),
    .mom_x_b  (in_mom_x_b),
    .mom_y_b  (in_mom_y_b),
    .mom_z_b  (in_mom_z_b),
    .tag_out  (prep_tag),
    .radicand (radicand)
  );

  tbim_sqrt #(.W(W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .tag_in   (prep_tag),
    .radicand (radicand),
    .tag_out  (root_tag),
    .root     (root)
  );

  tbim_skid #(.MW(W + 1)) u_skid (
    .clk              (clk),
    .rst_n            (rst_n),
    .tag_in           (root_tag),
    .mass_in          (root),
    .advance          (advance),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mass         (out_mass),
    .out_no_real_root (out_no_real_root)
  );

  assign in_stall = !advance;

endmodule

### hw/rtl/tbim_checker.sv
// Port-level checks for the invariant mass unit, bound to the top level.
`include "assert_macros.svh"

module tbim_checker #(
  parameter int COMPONENT_WIDTH = 20
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [COMPONENT_WIDTH:0]          out_mass,
  input logic                              out_no_real_root
);

  // a negative squared mass always reports zero mass
  `TBIM_ASSERT(a_nrr_zero_mass, out_valid && out_no_real_root |-> out_mass == '0)

  // input side only backs up behind a held result
  `TBIM_ASSERT(a_stall_needs_result, in_stall |-> out_valid)
  `TBIM_ASSERT(a_stall_rise_cause, $rose(in_stall) |-> $past(out_valid && out_stall))

  // held result keeps its value
  `TBIM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_mass))

  `TBIM_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && !in_stall)

endmodule

bind two_body_invariant_mass_unit tbim_checker #(
  .COMPONENT_WIDTH(COMPONENT_WIDTH)
) u_tbim_checker (.*);

### sim/tb_top.sv
// Testbench for two_body_invariant_mass_unit: directed and random four-vector pairs vs a predictor.
module tb_top;

  localparam int CW = 20;
  localparam int LATENCY = CW + 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAXC = 2 ** (CW - 1) - 1;
  localparam int MINC = -(2 ** (CW - 1));

  typedef struct {
    logic signed [CW-1:0] ea, xa, ya, za, eb, xb, yb, zb;
  } pair_t;

  typedef struct {
    logic [CW:0] mass;
    logic        no_root;
  } mass_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [CW-1:0] in_energy_a, in_mom_x_a, in_mom_y_a, in_mom_z_a;
  logic signed [CW-1:0] in_energy_b, in_mom_x_b, in_mom_y_b, in_mom_z_b;
  logic                 out_valid;
  logic                 out_stall;
  logic [CW:0]          out_mass;
  logic                 out_no_real_root;

  mass_result_t pending_masses[$];
  mass_result_t oldest_mass;
  int err_count = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int rcv_stall_pct = 0;

  two_body_invariant_mass_unit #(.COMPONENT_WIDTH(CW)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_energy_a(in_energy_a),
    .in_mom_x_a(in_mom_x_a),
    .in_mom_y_a(in_mom_y_a),
    .in_mom_z_a(in_mom_z_a),
    .in_energy_b(in_energy_b),
    .in_mom_x_b(in_mom_x_b),
    .in_mom_y_b(in_mom_y_b),
    .in_mom_z_b(in_mom_z_b),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_mass(out_mass),
    .out_no_real_root(out_no_real_root)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  function automatic longint isqrt(input longint v);
    longint r, c;
    r = 0;
    for (int b = CW; b >= 0; b--) begin
      c = r | (longint'(1) << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic longint mag3(input logic signed [CW-1:0] x, y, z);
    longint lx, ly, lz;
    lx = longint'(x);
    ly = longint'(y);
    lz = longint'(z);
    return isqrt(lx * lx + ly * ly + lz * lz);
  endfunction

  function automatic mass_result_t predict_mass(input pair_t p);
    longint e, x, y, z, e2, p2;
    mass_result_t r;
    e = longint'(p.ea) + longint'(p.eb);
    x = longint'(p.xa) + longint'(p.xb);
    y = longint'(p.ya) + longint'(p.yb);
    z = longint'(p.za) + longint'(p.zb);
    e2 = e * e;
    p2 = x * x + y * y + z * z;
    if (e2 < p2) begin
      r.mass = '0;
      r.no_root = 1'b1;
    end else begin
      r.mass = (CW + 1)'(isqrt(e2 - p2));
      r.no_root = 1'b0;
    end
    return r;
  endfunction

  function automatic pair_t mk_pair(input int ea, xa, ya, za, eb, xb, yb, zb);
    pair_t p;
    p.ea = CW'(ea); p.xa = CW'(xa); p.ya = CW'(ya); p.za = CW'(za);
    p.eb = CW'(eb); p.xb = CW'(xb); p.yb = CW'(yb); p.zb = CW'(zb);
    return p;
  endfunction

  function automatic logic signed [CW-1:0] rand_momentum();
    return CW'(int'($urandom_range(0, 2 ** 18 - 1)) - 2 ** 17);
  endfunction

  function automatic logic signed [CW-1:0] comp_extreme();
    case ($urandom_range(0, 5))
      0: return CW'(MAXC);
      1: return CW'(MINC);
      2: return '0;
      3: return CW'(1);
      4: return '1;
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 65) begin
      p.xa = rand_momentum(); p.ya = rand_momentum(); p.za = rand_momentum();
      p.xb = rand_momentum(); p.yb = rand_momentum(); p.zb = rand_momentum();
      if (mode < 45) begin
        // both timelike and on the same energy sign: the sum stays timelike
        p.ea = CW'(mag3(p.xa, p.ya, p.za) + $urandom_range(0, 2 ** 18 - 1));
        p.eb = CW'(mag3(p.xb, p.yb, p.zb) + $urandom_range(0, 2 ** 18 - 1));
        if ($urandom_range(0, 1)) begin
          p.ea = -p.ea;
          p.eb = -p.eb;
        end
      end else begin
        // near the light cone, signs free: lands on both sides of zero
        p.ea = CW'(mag3(p.xa, p.ya, p.za) + $urandom_range(0, 1));
        p.eb = CW'(mag3(p.xb, p.yb, p.zb) + $urandom_range(0, 1));
        if ($urandom_range(0, 1)) p.ea = -p.ea;
        if ($urandom_range(0, 1)) p.eb = -p.eb;
      end
    end else if (mode < 90) begin
      p.ea = CW'($urandom); p.xa = CW'($urandom);
      p.ya = CW'($urandom); p.za = CW'($urandom);
      p.eb = CW'($urandom); p.xb = CW'($urandom);
      p.yb = CW'($urandom); p.zb = CW'($urandom);
    end else begin
      p.ea = comp_extreme(); p.xa = comp_extreme();
      p.ya = comp_extreme(); p.za = comp_extreme();
      p.eb = comp_extreme(); p.xb = comp_extreme();
      p.yb = comp_extreme(); p.zb = comp_extreme();
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input longint want_v, input longint got_v);
    $display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what, want_v, got_v);
    err_count++;
  endtask

  task automatic drive_pair(input pair_t p);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_energy_a <= p.ea;
    in_mom_x_a  <= p.xa;
    in_mom_y_a  <= p.ya;
    in_mom_z_a  <= p.za;
    in_energy_b <= p.eb;
    in_mom_x_b  <= p.xb;
    in_mom_y_b  <= p.yb;
    in_mom_z_b  <= p.zb;
    do @(posedge clk); while (in_stall);
    pending_masses.push_back(predict_mass(p));
  endtask

  // sender holds off until the pipeline has delivered everything
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_masses.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_masses.size() == 0) begin
        report_mismatch("transaction with nothing pending, mass", longint'(-1),
                        longint'(out_mass));
      end else begin
        oldest_mass = pending_masses.pop_front();
        if (out_mass !== oldest_mass.mass)
          report_mismatch("mass", longint'(oldest_mass.mass), longint'(out_mass));
        if (out_no_real_root !== oldest_mass.no_root)
          report_mismatch("no_real_root", longint'(oldest_mass.no_root),
                          longint'(out_no_real_root));
      end
    end
  end

  task automatic test_directed();
    src_idle_pct = 0;
    rcv_stall_pct = 0;
    drive_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));               // zero mass, not an error
    drive_pair(mk_pair(MAXC, 0, 0, 0, MAXC, 0, 0, 0));
    drive_pair(mk_pair(MINC, 0, 0, 0, MINC, 0, 0, 0));         // largest mass
    drive_pair(mk_pair(MAXC, 0, 0, 0, MINC, 0, 0, 0));
    drive_pair(mk_pair(0, MINC, MINC, MINC, 0, MINC, MINC, MINC));
    drive_pair(mk_pair(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
    drive_pair(mk_pair(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC));
    drive_pair(mk_pair(5, 3, 4, 0, 0, 0, 0, 0));               // lightlike
    drive_pair(mk_pair(10, 1, 0, 0, 0, 0, 0, 0));              // 99 -> 9
    drive_pair(mk_pair(10, 0, 0, 0, 0, 0, 0, 0));
    drive_pair(mk_pair(5, 3, 4, 1, 0, 0, 0, 0));               // short by one
    drive_pair(mk_pair(100, 60, 0, 0, 100, -60, 0, 0));
    drive_pair(mk_pair(MAXC, MAXC, 0, 0, MAXC, MINC, 0, 0));
    drive_pair(mk_pair(-1000, 3, 4, 0, -2000, 0, 0, 0));
    drive_pair(mk_pair(MAXC, MAXC, 0, 0, 0, 0, 0, 0));
    drive_pair(mk_pair(0, 0, MAXC, 0, MAXC, 0, 0, 0));
    drive_pair(mk_pair(0, 0, 0, MINC, MINC, 0, 0, 0));
    drive_pair(mk_pair(1, 0, 0, 0, 0, 1, 0, 0));
    drive_pair(mk_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    drive_pair(mk_pair(MINC, MAXC, MAXC, MAXC, MINC, 1, 1, 1));
    drain_results();
  endtask

  task automatic test_stream(input int n_items, input int idle_pct, input int stall_pct);
    src_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
    repeat (n_items) drive_pair(random_pair());
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_energy_a = '0; in_mom_x_a = '0; in_mom_y_a = '0; in_mom_z_a = '0;
    in_energy_b = '0; in_mom_x_b = '0; in_mom_y_b = '0; in_mom_z_b = '0;
    out_stall = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_stream(480, 0, 0);
    test_stream(480, 88, 0);
    test_stream(480, 0, 88);
    test_stream(480, 33, 33);

    rcv_stall_pct = 0;
    // anything arriving now is unexpected
    repeat (2 * LATENCY) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
